// ===== src/ffra_pkg.sv =====
// Shared definitions for the first-fit range allocator: sizes, command and
// status codes, datapath operations and the status bundle. No dependencies.
package ffra_pkg;

    localparam int FREE_SLOTS  = 64;
    localparam int ALLOC_SLOTS = 64;
    localparam int ADDR_BITS   = 32;

    localparam int FR_AW = $clog2(FREE_SLOTS);
    localparam int FR_CW = $clog2(FREE_SLOTS + 1);
    localparam int LA_AW = $clog2(ALLOC_SLOTS);
    localparam int LA_CW = $clog2(ALLOC_SLOTS + 1);

    typedef logic [ADDR_BITS-1:0] word_t;
    typedef logic [FR_CW-1:0]     fcnt_t;
    typedef logic [LA_CW-1:0]     acnt_t;
    typedef logic [LA_AW-1:0]     aslot_t;

    typedef struct packed {
        word_t off;
        word_t len;
    } range_t;

    typedef enum logic [1:0] {
        CMD_ALLOC    = 2'd0,
        CMD_RELEASE  = 2'd1,
        CMD_CONTAINS = 2'd2,
        CMD_REINIT   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FAIL = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [5:0] {
        OP_NOP, OP_LOAD, OP_REINIT, OP_SET_FAIL, OP_SET_FULL,
        OP_FR_RD_IDX, OP_DIV_START, OP_ALIGN, OP_FIT, OP_IDX_INC, OP_WR_ONE,
        OP_SD_INIT, OP_FR_RD_SHP, OP_FR_WR_SH_INC, OP_FC_DEC,
        OP_SU_INIT, OP_FR_RD_SHM, OP_FR_WR_SH_DEC, OP_FC_INC,
        OP_WR_PREFIX, OP_WR_SUFFIX, OP_A_COMMIT,
        OP_LA_RD, OP_AIDX_INC, OP_R_FOUND, OP_PREV_ADV, OP_CUR_LATCH,
        OP_WR_MERGE_BOTH, OP_WR_MERGE_PREV, OP_WR_MERGE_NEXT, OP_WR_NEW,
        OP_R_COMMIT, OP_C_UPD, OP_C_FINAL, OP_OUT_LOAD
    } dp_op_t;

    typedef struct packed {
        cmd_t cmd;
        logic len_zero;
        logic align_zero;
        logic idx_end;
        logic aidx_end;
        logic div_busy;
        logic fit;
        logic need_pre;
        logic need_suf;
        logic fc_full;
        logic slot_avail;
        logic sd_end;
        logic su_end;
        logic la_hit;
        logic la_len_eq;
        logic prev_lt;
        logic mp;
        logic mn;
    } dp_stat_t;

endpackage

// ===== src/ffra_rem.sv =====
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on ffra_pkg.
module ffra_rem (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  ffra_pkg::word_t dividend,
    input  ffra_pkg::word_t divisor,
    output logic          busy,
    output ffra_pkg::word_t rem
);
    import ffra_pkg::*;

    localparam int CNT_W = $clog2(ADDR_BITS + 1);

    logic               busy_reg, busy_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    word_t              rem_reg, rem_next;
    word_t              dvd_reg, dvd_next;
    word_t              dsr_reg, dsr_next;
    logic [ADDR_BITS:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, dvd_reg[ADDR_BITS-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(ADDR_BITS);
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = word_t'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[ADDR_BITS-1:0];
            end
            dvd_next  = {dvd_reg[ADDR_BITS-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

// ===== src/ffra_datapath.sv =====
// Datapath of the allocator: free-range and allocation memories, valid bits,
// counters, alignment arithmetic and the result register.
// Depends on ffra_pkg and ffra_rem.
module ffra_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  ffra_pkg::dp_op_t  op,
    output ffra_pkg::dp_stat_t st,
    input  logic              cfg_wr_en,
    input  ffra_pkg::word_t   cfg_wr_data,
    input  logic [1:0]        command,
    input  ffra_pkg::word_t   offset,
    input  ffra_pkg::word_t   length,
    input  ffra_pkg::word_t   alignment,
    output logic [1:0]        status,
    output ffra_pkg::word_t   granted_offset,
    output ffra_pkg::word_t   free_bytes
);
    import ffra_pkg::*;

    range_t fr_mem [FREE_SLOTS];
    range_t la_mem [ALLOC_SLOTS];
    range_t fr_q, la_q;

    logic             fr_we, fr_re, la_we, la_re;
    logic [FR_AW-1:0] fr_wa, fr_ra;
    range_t           fr_wd;

    // Control state.
    fcnt_t                  fc_reg, fc_next;
    word_t                  avail_reg, avail_next;
    word_t                  cap_reg;
    logic [ALLOC_SLOTS-1:0] valid_reg, valid_next;
    logic                   have_prev_reg, have_prev_next;
    logic                   found_reg, found_next;

    // Working registers.
    cmd_t    cmd_reg, cmd_next;
    word_t   off_reg, off_next, len_reg, len_next, align_reg, align_next;
    fcnt_t   idx_reg, idx_next, sh_reg, sh_next;
    acnt_t   aidx_reg, aidx_next;
    range_t  cur_reg, cur_next, prev_reg, prev_next, best_reg, best_next;
    word_t   al_reg, al_next, prefix_reg, prefix_next, used_reg, used_next;
    logic    al_ok_reg, al_ok_next, fit_reg, fit_next;
    logic    npre_reg, npre_next, nsuf_reg, nsuf_next;
    aslot_t  slot_reg, slot_next;
    status_t res_st_reg, res_st_next;
    word_t   gr_reg, gr_next;
    status_t out_st_reg, out_st_next;
    word_t   out_gr_reg, out_gr_next, out_fb_reg, out_fb_next;

    logic               div_busy;
    word_t              div_rem;
    word_t              pad, prefix_c, used_c;
    logic [ADDR_BITS:0] al_sum, mp_sum, mn_sum;
    aslot_t             free_slot;
    logic               slot_avail;
    fcnt_t              su_base;
    aslot_t             aidx_a;

    ffra_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (op == OP_DIV_START),
        .dividend (fr_q.off),
        .divisor  (align_reg),
        .busy     (div_busy),
        .rem      (div_rem)
    );

    // Lowest invalid allocation slot.
    always_comb
    begin
        free_slot  = '0;
        slot_avail = 1'b0;
        for (int i = ALLOC_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_slot  = aslot_t'(i);
                slot_avail = 1'b1;
            end
        end
    end

    assign aidx_a   = aidx_reg[LA_AW-1:0];
    assign pad      = align_reg - div_rem;
    assign al_sum   = {1'b0, cur_reg.off} + {1'b0, pad};
    assign prefix_c = al_reg - cur_reg.off;
    assign used_c   = prefix_c + len_reg;
    assign mp_sum   = {1'b0, prev_reg.off} + {1'b0, prev_reg.len};
    assign mn_sum   = {1'b0, off_reg} + {1'b0, len_reg};
    assign su_base  = (cmd_reg == CMD_ALLOC) ? fcnt_t'(idx_reg + 1'b1) : idx_reg;

    always_comb
    begin
        st.cmd        = cmd_reg;
        st.len_zero   = (len_reg == '0);
        st.align_zero = (align_reg == '0);
        st.idx_end    = (idx_reg >= fc_reg);
        st.aidx_end   = (aidx_reg == acnt_t'(ALLOC_SLOTS));
        st.div_busy   = div_busy;
        st.fit        = fit_reg;
        st.need_pre   = npre_reg;
        st.need_suf   = nsuf_reg;
        st.fc_full    = (fc_reg == fcnt_t'(FREE_SLOTS));
        st.slot_avail = slot_avail;
        st.sd_end     = ((FR_CW+1)'(sh_reg) + (FR_CW+1)'(1)) >= (FR_CW+1)'(fc_reg);
        st.su_end     = (sh_reg <= su_base);
        st.la_hit     = valid_reg[aidx_a] && (la_q.off == off_reg);
        st.la_len_eq  = (la_q.len == len_reg);
        st.prev_lt    = (fr_q.off < off_reg);
        st.mp         = have_prev_reg && (mp_sum == {1'b0, off_reg});
        st.mn         = (idx_reg < fc_reg) && (mn_sum == {1'b0, cur_reg.off});
    end

    always_comb
    begin
        fr_we = 1'b0; fr_re = 1'b0; la_we = 1'b0; la_re = 1'b0;
        fr_wa = idx_reg[FR_AW-1:0];
        fr_ra = idx_reg[FR_AW-1:0];
        fr_wd = '0;
        fc_next = fc_reg; avail_next = avail_reg; valid_next = valid_reg;
        have_prev_next = have_prev_reg; found_next = found_reg;
        cmd_next = cmd_reg; off_next = off_reg; len_next = len_reg;
        align_next = align_reg; idx_next = idx_reg; sh_next = sh_reg;
        aidx_next = aidx_reg; cur_next = cur_reg; prev_next = prev_reg;
        best_next = best_reg; al_next = al_reg; al_ok_next = al_ok_reg;
        prefix_next = prefix_reg; used_next = used_reg; fit_next = fit_reg;
        npre_next = npre_reg; nsuf_next = nsuf_reg; slot_next = slot_reg;
        res_st_next = res_st_reg; gr_next = gr_reg;
        out_st_next = out_st_reg; out_gr_next = out_gr_reg; out_fb_next = out_fb_reg;

        case (op)
            OP_LOAD:
            begin
                cmd_next = cmd_t'(command);
                off_next = offset; len_next = length; align_next = alignment;
                idx_next = '0; aidx_next = '0;
                have_prev_next = 1'b0; found_next = 1'b0;
                gr_next = '0;
            end
            OP_REINIT:
            begin
                valid_next = '0;
                avail_next = cap_reg;
                fc_next    = (cap_reg != '0) ? fcnt_t'(1) : '0;
                fr_we      = (cap_reg != '0);
                fr_wa      = '0;
                fr_wd      = '{off: '0, len: cap_reg};
                res_st_next = ST_OK;
            end
            OP_SET_FAIL: res_st_next = ST_FAIL;
            OP_SET_FULL: res_st_next = ST_FULL;
            OP_FR_RD_IDX: fr_re = 1'b1;
            OP_DIV_START: cur_next = fr_q;
            OP_ALIGN:
            begin
                if (div_rem == '0)
                begin
                    al_next = cur_reg.off; al_ok_next = 1'b1;
                end
                else
                begin
                    al_next = al_sum[ADDR_BITS-1:0]; al_ok_next = !al_sum[ADDR_BITS];
                end
            end
            OP_FIT:
            begin
                prefix_next = prefix_c;
                used_next   = used_c;
                fit_next    = al_ok_reg && (prefix_c <= cur_reg.len)
                              && (len_reg <= cur_reg.len - prefix_c);
                npre_next   = (prefix_c != '0);
                nsuf_next   = (used_c < cur_reg.len);
            end
            OP_IDX_INC: idx_next = idx_reg + 1'b1;
            OP_WR_ONE:
            begin
                fr_we = 1'b1;
                if (npre_reg)
                    fr_wd = '{off: cur_reg.off, len: prefix_reg};
                else
                    fr_wd = '{off: cur_reg.off + used_reg, len: cur_reg.len - used_reg};
            end
            OP_SD_INIT: sh_next = idx_reg;
            OP_FR_RD_SHP:
            begin
                fr_re = 1'b1;
                fr_ra = FR_AW'(sh_reg + 1'b1);
            end
            OP_FR_WR_SH_INC:
            begin
                fr_we = 1'b1; fr_wa = sh_reg[FR_AW-1:0]; fr_wd = fr_q;
                sh_next = sh_reg + 1'b1;
            end
            OP_FC_DEC: fc_next = fc_reg - 1'b1;
            OP_SU_INIT: sh_next = fc_reg;
            OP_FR_RD_SHM:
            begin
                fr_re = 1'b1;
                fr_ra = FR_AW'(sh_reg - 1'b1);
            end
            OP_FR_WR_SH_DEC:
            begin
                fr_we = 1'b1; fr_wa = sh_reg[FR_AW-1:0]; fr_wd = fr_q;
                sh_next = sh_reg - 1'b1;
            end
            OP_FC_INC: fc_next = fc_reg + 1'b1;
            OP_WR_PREFIX:
            begin
                fr_we = 1'b1;
                fr_wd = '{off: cur_reg.off, len: prefix_reg};
            end
            OP_WR_SUFFIX:
            begin
                fr_we = 1'b1;
                fr_wa = FR_AW'(idx_reg + 1'b1);
                fr_wd = '{off: cur_reg.off + used_reg, len: cur_reg.len - used_reg};
            end
            OP_A_COMMIT:
            begin
                la_we = 1'b1;
                slot_next = free_slot;
                valid_next[free_slot] = 1'b1;
                avail_next  = avail_reg - len_reg;
                res_st_next = ST_OK;
                gr_next     = al_reg;
            end
            OP_LA_RD: la_re = 1'b1;
            OP_AIDX_INC: aidx_next = aidx_reg + 1'b1;
            OP_R_FOUND:
            begin
                slot_next = aidx_a;
                idx_next  = '0;
                have_prev_next = 1'b0;
            end
            OP_PREV_ADV:
            begin
                prev_next = fr_q; have_prev_next = 1'b1;
                idx_next  = idx_reg + 1'b1;
            end
            OP_CUR_LATCH: cur_next = fr_q;
            OP_WR_MERGE_BOTH:
            begin
                fr_we = 1'b1; fr_wa = FR_AW'(idx_reg - 1'b1);
                fr_wd = '{off: prev_reg.off, len: prev_reg.len + len_reg + cur_reg.len};
                sh_next = idx_reg;
            end
            OP_WR_MERGE_PREV:
            begin
                fr_we = 1'b1; fr_wa = FR_AW'(idx_reg - 1'b1);
                fr_wd = '{off: prev_reg.off, len: prev_reg.len + len_reg};
            end
            OP_WR_MERGE_NEXT:
            begin
                fr_we = 1'b1;
                fr_wd = '{off: off_reg, len: cur_reg.len + len_reg};
            end
            OP_WR_NEW:
            begin
                fr_we = 1'b1;
                fr_wd = '{off: off_reg, len: len_reg};
            end
            OP_R_COMMIT:
            begin
                valid_next[slot_reg] = 1'b0;
                avail_next  = avail_reg + len_reg;
                res_st_next = ST_OK;
            end
            OP_C_UPD:
            begin
                if (valid_reg[aidx_a] && (la_q.off <= off_reg)
                    && (!found_reg || (la_q.off > best_reg.off)))
                begin
                    best_next = la_q; found_next = 1'b1;
                end
                aidx_next = aidx_reg + 1'b1;
            end
            OP_C_FINAL:
            begin
                if (found_reg && (len_reg <= best_reg.len)
                    && (off_reg - best_reg.off <= best_reg.len - len_reg))
                    res_st_next = ST_OK;
                else
                    res_st_next = ST_FAIL;
            end
            OP_OUT_LOAD:
            begin
                out_st_next = res_st_reg;
                out_gr_next = (res_st_reg == ST_OK) ? gr_reg : '0;
                out_fb_next = avail_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fr_we)
            fr_mem[fr_wa] <= fr_wd;
        if (fr_re)
            fr_q <= fr_mem[fr_ra];
    end

    always_ff @(posedge clk)
    begin
        if (la_we)
            la_mem[free_slot] <= '{off: al_reg, len: len_reg};
        if (la_re)
            la_q <= la_mem[aidx_a];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg        <= '0;
            avail_reg     <= '0;
            cap_reg       <= '0;
            valid_reg     <= '0;
            have_prev_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            fc_reg        <= fc_next;
            avail_reg     <= avail_next;
            valid_reg     <= valid_next;
            have_prev_reg <= have_prev_next;
            found_reg     <= found_next;
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next; off_reg <= off_next; len_reg <= len_next;
        align_reg <= align_next; idx_reg <= idx_next; sh_reg <= sh_next;
        aidx_reg <= aidx_next; cur_reg <= cur_next; prev_reg <= prev_next;
        best_reg <= best_next; al_reg <= al_next; al_ok_reg <= al_ok_next;
        prefix_reg <= prefix_next; used_reg <= used_next; fit_reg <= fit_next;
        npre_reg <= npre_next; nsuf_reg <= nsuf_next; slot_reg <= slot_next;
        res_st_reg <= res_st_next; gr_reg <= gr_next;
        out_st_reg <= out_st_next; out_gr_reg <= out_gr_next; out_fb_reg <= out_fb_next;
    end

    assign status         = out_st_reg;
    assign granted_offset = out_gr_reg;
    assign free_bytes     = out_fb_reg;

endmodule

// ===== src/ffra_ctrl.sv =====
// Sequencer of the allocator: one-hot state machine issuing at most one
// datapath operation per cycle and running both handshakes. Depends on ffra_pkg.
module ffra_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  ffra_pkg::dp_stat_t st,
    output ffra_pkg::dp_op_t   op
);
    import ffra_pkg::*;

    typedef enum logic [23:0] {
        S_IDLE     = 24'h000001, S_DISPATCH = 24'h000002, S_A_CHK    = 24'h000004,
        S_A_WAIT   = 24'h000008, S_A_DIV    = 24'h000010, S_A_FIT    = 24'h000020,
        S_A_DEC    = 24'h000040, S_A_WR2A   = 24'h000080, S_A_WR2B   = 24'h000100,
        S_A_COMMIT = 24'h000200, S_SD_CHK   = 24'h000400, S_SD_WR    = 24'h000800,
        S_SU_CHK   = 24'h001000, S_SU_WR    = 24'h002000, S_R_LRD    = 24'h004000,
        S_R_LCHK   = 24'h008000, S_R_PRD    = 24'h010000, S_R_PCHK   = 24'h020000,
        S_R_DEC    = 24'h040000, S_R_WRNEW  = 24'h080000, S_R_COMMIT = 24'h100000,
        S_C_RD     = 24'h200000, S_C_CHK    = 24'h400000, S_DONE     = 24'h800000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   is_alloc;

    assign is_alloc = (st.cmd == CMD_ALLOC);

    always_comb
    begin
        state_next     = state_reg;
        op             = OP_NOP;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op = OP_LOAD; state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (st.cmd)
                    CMD_REINIT:
                    begin
                        op = OP_REINIT; state_next = S_DONE;
                    end
                    CMD_ALLOC:
                    begin
                        if (st.len_zero || st.align_zero)
                        begin
                            op = OP_SET_FAIL; state_next = S_DONE;
                        end
                        else
                            state_next = S_A_CHK;
                    end
                    CMD_RELEASE: state_next = S_R_LRD;
                    CMD_CONTAINS:
                    begin
                        if (st.len_zero)
                        begin
                            op = OP_SET_FAIL; state_next = S_DONE;
                        end
                        else
                            state_next = S_C_RD;
                    end
                    default:
                    begin
                        op = OP_SET_FAIL; state_next = S_DONE;
                    end
                endcase
            end
            S_A_CHK:
            begin
                if (st.idx_end)
                begin
                    op = OP_SET_FAIL; state_next = S_DONE;
                end
                else
                begin
                    op = OP_FR_RD_IDX; state_next = S_A_WAIT;
                end
            end
            S_A_WAIT:
            begin
                op = OP_DIV_START; state_next = S_A_DIV;
            end
            S_A_DIV:
            begin
                if (!st.div_busy)
                begin
                    op = OP_ALIGN; state_next = S_A_FIT;
                end
            end
            S_A_FIT:
            begin
                op = OP_FIT; state_next = S_A_DEC;
            end
            S_A_DEC:
            begin
                if (!st.fit)
                begin
                    op = OP_IDX_INC; state_next = S_A_CHK;
                end
                else if ((st.need_pre && st.need_suf && st.fc_full) || !st.slot_avail)
                begin
                    op = OP_SET_FULL; state_next = S_DONE;
                end
                else if (st.need_pre && st.need_suf)
                begin
                    op = OP_SU_INIT; state_next = S_SU_CHK;
                end
                else if (st.need_pre || st.need_suf)
                begin
                    op = OP_WR_ONE; state_next = S_A_COMMIT;
                end
                else
                begin
                    op = OP_SD_INIT; state_next = S_SD_CHK;
                end
            end
            S_SD_CHK:
            begin
                if (st.sd_end)
                begin
                    op = OP_FC_DEC;
                    state_next = is_alloc ? S_A_COMMIT : S_R_COMMIT;
                end
                else
                begin
                    op = OP_FR_RD_SHP; state_next = S_SD_WR;
                end
            end
            S_SD_WR:
            begin
                op = OP_FR_WR_SH_INC; state_next = S_SD_CHK;
            end
            S_SU_CHK:
            begin
                if (st.su_end)
                begin
                    op = OP_FC_INC;
                    state_next = is_alloc ? S_A_WR2A : S_R_WRNEW;
                end
                else
                begin
                    op = OP_FR_RD_SHM; state_next = S_SU_WR;
                end
            end
            S_SU_WR:
            begin
                op = OP_FR_WR_SH_DEC; state_next = S_SU_CHK;
            end
            S_A_WR2A:
            begin
                op = OP_WR_PREFIX; state_next = S_A_WR2B;
            end
            S_A_WR2B:
            begin
                op = OP_WR_SUFFIX; state_next = S_A_COMMIT;
            end
            S_A_COMMIT:
            begin
                op = OP_A_COMMIT; state_next = S_DONE;
            end
            S_R_LRD:
            begin
                if (st.aidx_end)
                begin
                    op = OP_SET_FAIL; state_next = S_DONE;
                end
                else
                begin
                    op = OP_LA_RD; state_next = S_R_LCHK;
                end
            end
            S_R_LCHK:
            begin
                if (st.la_hit && st.la_len_eq)
                begin
                    op = OP_R_FOUND; state_next = S_R_PRD;
                end
                else if (st.la_hit)
                begin
                    op = OP_SET_FAIL; state_next = S_DONE;
                end
                else
                begin
                    op = OP_AIDX_INC; state_next = S_R_LRD;
                end
            end
            S_R_PRD:
            begin
                if (st.idx_end)
                    state_next = S_R_DEC;
                else
                begin
                    op = OP_FR_RD_IDX; state_next = S_R_PCHK;
                end
            end
            S_R_PCHK:
            begin
                if (st.prev_lt)
                begin
                    op = OP_PREV_ADV; state_next = S_R_PRD;
                end
                else
                begin
                    op = OP_CUR_LATCH; state_next = S_R_DEC;
                end
            end
            S_R_DEC:
            begin
                if (!st.mp && !st.mn && st.fc_full)
                begin
                    op = OP_SET_FULL; state_next = S_DONE;
                end
                else if (st.mp && st.mn)
                begin
                    op = OP_WR_MERGE_BOTH; state_next = S_SD_CHK;
                end
                else if (st.mp)
                begin
                    op = OP_WR_MERGE_PREV; state_next = S_R_COMMIT;
                end
                else if (st.mn)
                begin
                    op = OP_WR_MERGE_NEXT; state_next = S_R_COMMIT;
                end
                else
                begin
                    op = OP_SU_INIT; state_next = S_SU_CHK;
                end
            end
            S_R_WRNEW:
            begin
                op = OP_WR_NEW; state_next = S_R_COMMIT;
            end
            S_R_COMMIT:
            begin
                op = OP_R_COMMIT; state_next = S_DONE;
            end
            S_C_RD:
            begin
                if (st.aidx_end)
                begin
                    op = OP_C_FINAL; state_next = S_DONE;
                end
                else
                begin
                    op = OP_LA_RD; state_next = S_C_CHK;
                end
            end
            S_C_CHK:
            begin
                op = OP_C_UPD; state_next = S_C_RD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    op = OP_OUT_LOAD; out_valid_next = 1'b1; state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== src/first_fit_range_allocator_unit.sv =====
// Top level of the first-fit range allocator: sequencer plus datapath.
// Depends on ffra_pkg, ffra_ctrl and ffra_datapath.
//
//   Channel   Handshake            Payload
//   -------   ------------------   ------------------------------------------
//   config    cfg_wr_en            cfg_wr_data (capacity)
//   input     in_valid / in_ready  command, offset, length, alignment
//   output    out_valid/out_ready  status, granted_offset, free_bytes
//
// One command is worked on at a time; a new transfer is taken when the
// sequencer is idle, even while the previous result still waits at the output.
// Allocate runs the bit-serial remainder unit for every free range it visits
// and may shift entries of the free list; release scans the allocation table
// and then the free list; contains walks all allocation slots.
// Reset is asynchronous and active low; it clears the valid bits, the counts
// and the capacity register at once, so no clearing pass is needed.
// A stalled output only holds the sequencer in its final state.
module first_fit_range_allocator_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  ffra_pkg::word_t cfg_wr_data,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      command,
    input  ffra_pkg::word_t offset,
    input  ffra_pkg::word_t length,
    input  ffra_pkg::word_t alignment,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [1:0]      status,
    output ffra_pkg::word_t granted_offset,
    output ffra_pkg::word_t free_bytes
);
    import ffra_pkg::*;

    dp_op_t   op;
    dp_stat_t st;

    // The sequencer decides the operation; the datapath reports back.
    ffra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .op        (op)
    );

    // The datapath holds both tables, the counters and the result register.
    ffra_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .st             (st),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .command        (command),
        .offset         (offset),
        .length         (length),
        .alignment      (alignment),
        .status         (status),
        .granted_offset (granted_offset),
        .free_bytes     (free_bytes)
    );

endmodule

// ===== src/ffra_checker.sv =====
// Port-level checks for the allocator, attached to the top level by bind.
// Depends on ffra_pkg.
module ffra_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input logic [1:0]      status,
    input ffra_pkg::word_t granted_offset
);
    import ffra_pkg::*;

    // Only one command is in flight: a transfer in makes the block busy.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a command was in progress");

    // A failed or full command never reports a granted offset.
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> granted_offset == '0)
        else $error("nonzero grant on a failed command");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK) || (status == ST_FAIL) || (status == ST_FULL))
        else $error("undefined status code");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
                                    && $stable(granted_offset))
        else $error("result changed while stalled");

endmodule

bind first_fit_range_allocator_unit ffra_checker u_ffra_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .granted_offset (granted_offset)
);

// ===== tb/sv/tb_first_fit_range_allocator_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for first_fit_range_allocator_unit: a scoreboard
// class predicts every result from the commands it sees accepted.
// Depends on ffra_pkg and the allocator RTL only.
module tb_first_fit_range_allocator_unit;
    import ffra_pkg::*;

    localparam longint unsigned ADDR_MAX = (64'd1 << ADDR_BITS) - 1;

    // The scoreboard carries its own copy of the free list, the allocation
    // table and the byte count, and queues the results it expects.
    class range_scoreboard;
        longint unsigned capacity;
        longint unsigned avail;
        longint unsigned fr_off[FREE_SLOTS];
        longint unsigned fr_len[FREE_SLOTS];
        int              fcount;
        bit              la_v[ALLOC_SLOTS];
        longint unsigned la_o[ALLOC_SLOTS];
        longint unsigned la_l[ALLOC_SLOTS];
        status_t         exp_status[$];
        word_t           exp_granted[$];
        word_t           exp_free[$];
        int              errors;

        function new();
            capacity = 0;
            errors   = 0;
            reinit_arena();
            avail = 0;
        endfunction

        function void reinit_arena();
            for (int j = 0; j < ALLOC_SLOTS; j++)
            begin
                la_v[j] = 0;
                la_o[j] = 0;
                la_l[j] = 0;
            end
            fcount = 0;
            avail  = capacity;
            if (capacity != 0)
            begin
                fr_off[0] = 0;
                fr_len[0] = capacity;
                fcount    = 1;
            end
        endfunction

        function status_t first_fit(longint unsigned len, longint unsigned al,
                                    output longint unsigned granted);
            longint unsigned o, r, a, rem, pad, pre, used;
            int need, slot;
            granted = 0;
            if (len == 0 || al == 0)
                return ST_FAIL;
            for (int i = 0; i < fcount; i++)
            begin
                o   = fr_off[i];
                r   = fr_len[i];
                rem = o % al;
                if (rem == 0)
                    a = o;
                else
                begin
                    pad = al - rem;
                    // Aligning past the top of the address space skips the range.
                    if (o > ADDR_MAX - pad)
                        continue;
                    a = o + pad;
                end
                pre = a - o;
                if (pre > r || len > r - pre)
                    continue;
                used = pre + len;
                need = (pre != 0 ? 1 : 0) + (used < r ? 1 : 0);
                if (need == 2 && fcount >= FREE_SLOTS)
                    return ST_FULL;
                slot = ALLOC_SLOTS;
                for (int j = 0; j < ALLOC_SLOTS; j++)
                    if (la_v[j] && la_o[j] == a)
                    begin
                        slot = j;
                        break;
                    end
                if (slot == ALLOC_SLOTS)
                    for (int j = 0; j < ALLOC_SLOTS; j++)
                        if (!la_v[j])
                        begin
                            slot = j;
                            break;
                        end
                if (slot == ALLOC_SLOTS)
                    return ST_FULL;
                if (need == 0)
                begin
                    for (int j = i; j + 1 < fcount; j++)
                    begin
                        fr_off[j] = fr_off[j+1];
                        fr_len[j] = fr_len[j+1];
                    end
                    fcount--;
                end
                else if (need == 1)
                begin
                    if (pre != 0)
                        fr_len[i] = pre;
                    else
                    begin
                        fr_off[i] = o + used;
                        fr_len[i] = r - used;
                    end
                end
                else
                begin
                    for (int j = fcount; j > i + 1; j--)
                    begin
                        fr_off[j] = fr_off[j-1];
                        fr_len[j] = fr_len[j-1];
                    end
                    fr_len[i]   = pre;
                    fr_off[i+1] = o + used;
                    fr_len[i+1] = r - used;
                    fcount++;
                end
                la_v[slot] = 1;
                la_o[slot] = a;
                la_l[slot] = len;
                avail      = (avail - len) & 64'hFFFF_FFFF;
                granted    = a;
                return ST_OK;
            end
            return ST_FAIL;
        endfunction

        function status_t give_back(longint unsigned off, longint unsigned len);
            int  slot, pos;
            bit  mp, mn;
            slot = ALLOC_SLOTS;
            for (int j = 0; j < ALLOC_SLOTS; j++)
                if (la_v[j] && la_o[j] == off)
                begin
                    slot = j;
                    break;
                end
            if (slot == ALLOC_SLOTS || la_l[slot] != len)
                return ST_FAIL;
            pos = 0;
            while (pos < fcount && fr_off[pos] < off)
                pos++;
            mp = pos > 0 && fr_off[pos-1] + fr_len[pos-1] == off;
            mn = pos < fcount && off + len == fr_off[pos];
            if (!mp && !mn && fcount >= FREE_SLOTS)
                return ST_FULL;
            if (mp && mn)
            begin
                fr_len[pos-1] += len + fr_len[pos];
                for (int j = pos; j + 1 < fcount; j++)
                begin
                    fr_off[j] = fr_off[j+1];
                    fr_len[j] = fr_len[j+1];
                end
                fcount--;
            end
            else if (mp)
                fr_len[pos-1] += len;
            else if (mn)
            begin
                fr_off[pos] = off;
                fr_len[pos] += len;
            end
            else
            begin
                for (int j = fcount; j > pos; j--)
                begin
                    fr_off[j] = fr_off[j-1];
                    fr_len[j] = fr_len[j-1];
                end
                fr_off[pos] = off;
                fr_len[pos] = len;
                fcount++;
            end
            la_v[slot] = 0;
            avail = (avail + len) & 64'hFFFF_FFFF;
            return ST_OK;
        endfunction

        // The span must lie inside the allocation with the highest start
        // that is not above the queried offset.
        function status_t span_inside(longint unsigned off, longint unsigned len);
            int best;
            best = ALLOC_SLOTS;
            if (len == 0)
                return ST_FAIL;
            for (int j = 0; j < ALLOC_SLOTS; j++)
                if (la_v[j] && la_o[j] <= off && (best == ALLOC_SLOTS || la_o[j] > la_o[best]))
                    best = j;
            if (best == ALLOC_SLOTS)
                return ST_FAIL;
            return (len <= la_l[best] && off - la_o[best] <= la_l[best] - len) ? ST_OK : ST_FAIL;
        endfunction

        function void note_command(cmd_t cmd, word_t off, word_t len, word_t al);
            longint unsigned g;
            status_t st;
            g = 0;
            case (cmd)
                CMD_ALLOC:    st = first_fit(64'(len), 64'(al), g);
                CMD_RELEASE:  st = give_back(64'(off), 64'(len));
                CMD_CONTAINS: st = span_inside(64'(off), 64'(len));
                default:
                begin
                    reinit_arena();
                    st = ST_OK;
                end
            endcase
            if (st != ST_OK)
                g = 0;
            exp_status  = {exp_status, st};
            exp_granted = {exp_granted, word_t'(g)};
            exp_free    = {exp_free, word_t'(avail)};
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        task check_result(logic [1:0] st, word_t go, word_t fb);
            status_t es;
            word_t eg, ef;
            if (exp_status.size() == 0)
            begin
                report("result transfer with nothing expected");
                return;
            end
            es = exp_status.pop_front();
            eg = exp_granted.pop_front();
            ef = exp_free.pop_front();
            if (st !== es)
                report($sformatf("status %0d, expected %0d", st, es));
            if (go !== eg)
                report($sformatf("granted_offset %h, expected %h", go, eg));
            if (fb !== ef)
                report($sformatf("free_bytes %h, expected %h", fb, ef));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    word_t       cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    word_t       offset;
    word_t       length;
    word_t       alignment;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    word_t       granted_offset;
    word_t       free_bytes;

    range_scoreboard sb;
    int snd_idle;
    int rcv_stall;
    int hold_req;
    int hold_cnt;

    first_fit_range_allocator_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .offset         (offset),
        .length         (length),
        .alignment      (alignment),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .granted_offset (granted_offset),
        .free_bytes     (free_bytes)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Receiver: stalls at random, or holds off for a long counted stretch
    // when the main process asks for one, so the block backs up its input.
    initial
    begin
        out_ready = 0;
        hold_cnt  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold_cnt = hold_req;
                hold_req = 0;
            end
            if (hold_cnt > 0)
            begin
                out_ready = 0;
                hold_cnt--;
            end
            else
                out_ready = ($urandom_range(99) >= rcv_stall);
        end
    end

    // Every result transfer is checked at the edge where it happens.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_result(status, granted_offset, free_bytes);
        end
    end

    // Presents one command and holds it until the transfer is taken.
    task send_cmd(cmd_t c, word_t off, word_t len, word_t al);
        if ($urandom_range(99) < snd_idle)
        begin
            in_valid = 0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid  = 1;
        command   = c;
        offset    = off;
        length    = len;
        alignment = al;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_command(c, off, len, al);
        @(negedge clk);
    endtask

    // Only called when the block is idle: nothing expected is outstanding.
    task write_capacity(word_t v);
        cfg_wr_en   = 1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en = 0;
        sb.capacity = 64'(v);
    endtask

    task wait_drained();
        in_valid = 0;
        while (sb.exp_status.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        @(negedge clk);
    endtask

    function word_t pick_align();
        case ($urandom_range(11))
            0:  return 1;
            1:  return 2;
            2:  return 4;
            3:  return 8;
            4:  return 64;
            5:  return 3;
            6:  return 7;
            7:  return $urandom_range(1, 100);
            8:  return ($urandom_range(9) == 0) ? 32'd0 : 32'd16;
            9:  return $urandom;
            10: return 32'h8000_0000;
            default: return 1;
        endcase
    endfunction

    // Mostly well-formed traffic against the live allocations, with some
    // mismatched releases and plain noise mixed in.
    task random_cmd();
        int    r, live[$];
        word_t o, l, d;
        r = $urandom_range(99);
        for (int j = 0; j < ALLOC_SLOTS; j++)
            if (sb.la_v[j])
                live = {live, j};
        if (r < 3)
            send_cmd(CMD_REINIT, $urandom, $urandom, $urandom);
        else if (r < 48)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: l = $urandom_range(1, 64);
                6, 7:             l = $urandom_range(1, 4096);
                8:                l = $urandom;
                default:          l = ($urandom_range(3) == 0) ? 32'd0 : $urandom >> $urandom_range(31);
            endcase
            send_cmd(CMD_ALLOC, $urandom, l, pick_align());
        end
        else if (r < 73)
        begin
            if (live.size() != 0 && $urandom_range(99) < 85)
            begin
                d = live[$urandom_range(live.size() - 1)];
                l = word_t'(sb.la_l[d]);
                if ($urandom_range(9) == 0)
                    l = l + $urandom_range(1, 3);
                send_cmd(CMD_RELEASE, word_t'(sb.la_o[d]), l, $urandom);
            end
            else
                send_cmd(CMD_RELEASE, $urandom, $urandom, $urandom);
        end
        else if (r < 93)
        begin
            if (live.size() != 0 && $urandom_range(99) < 80)
            begin
                d = live[$urandom_range(live.size() - 1)];
                o = $urandom_range(0, word_t'(sb.la_l[d]) - 1);
                l = $urandom_range(1, word_t'(sb.la_l[d]) - o);
                if ($urandom_range(4) == 0)
                    l = l + 1;
                send_cmd(CMD_CONTAINS, word_t'(sb.la_o[d]) + o, l, $urandom);
            end
            else
                send_cmd(CMD_CONTAINS, $urandom, $urandom >> $urandom_range(31), $urandom);
        end
        else
            send_cmd(cmd_t'($urandom_range(2)), $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        word_t caps[8];
        sb          = new();
        snd_idle    = 0;
        rcv_stall   = 0;
        hold_req    = 0;
        rst_n       = 0;
        cfg_wr_en   = 0;
        cfg_wr_data = 0;
        in_valid    = 0;
        command     = CMD_ALLOC;
        offset      = 0;
        length      = 0;
        alignment   = 0;
        repeat (4) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: a small arena exercising each command and failure path.
        write_capacity(1000);
        send_cmd(CMD_ALLOC, 0, 1, 1);          // before any reinit: no free range
        send_cmd(CMD_REINIT, 0, 0, 0);
        send_cmd(CMD_ALLOC, 0, 0, 1);          // zero length
        send_cmd(CMD_ALLOC, 0, 10, 0);         // zero alignment
        send_cmd(CMD_ALLOC, 0, 10, 1);
        send_cmd(CMD_ALLOC, 0, 5, 16);         // leaves a prefix and a suffix
        send_cmd(CMD_ALLOC, 0, 2000, 1);       // nothing fits
        send_cmd(CMD_CONTAINS, 0, 10, 0);
        send_cmd(CMD_CONTAINS, 2, 8, 0);
        send_cmd(CMD_CONTAINS, 5, 10, 0);
        send_cmd(CMD_CONTAINS, 0, 0, 0);
        send_cmd(CMD_RELEASE, 0, 9, 0);        // length mismatch
        send_cmd(CMD_RELEASE, 3, 5, 0);        // no allocation there
        send_cmd(CMD_RELEASE, 0, 10, 0);
        send_cmd(CMD_RELEASE, 16, 5, 0);       // merges on both sides
        send_cmd(CMD_ALLOC, 0, 1000, 1000);    // takes the whole range
        send_cmd(CMD_ALLOC, 0, 1, 1);
        send_cmd(CMD_RELEASE, 0, 1000, 0);
        wait_drained();

        // Full 32-bit arena: alignment that runs off the top is skipped.
        write_capacity(32'hFFFF_FFFF);
        send_cmd(CMD_REINIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_ALLOC, 0, 32'hF000_0001, 1);
        send_cmd(CMD_ALLOC, 0, 1, 32'h8000_0000);
        send_cmd(CMD_ALLOC, 0, 1, 32'hFFFF_FFFF);
        send_cmd(CMD_ALLOC, 0, 32'h0FFF_FFFE, 1);
        send_cmd(CMD_CONTAINS, 32'hFFFF_FFFE, 1, 0);

        // Fragment the free list until it is full, then fill the allocation
        // table in a small arena.
        send_cmd(CMD_REINIT, 0, 0, 0);
        repeat (66) send_cmd(CMD_ALLOC, 0, 1, 2);
        send_cmd(CMD_RELEASE, 2, 1, 0);
        send_cmd(CMD_RELEASE, 0, 1, 0);
        wait_drained();
        write_capacity(100);
        send_cmd(CMD_REINIT, 0, 0, 0);
        repeat (66) send_cmd(CMD_ALLOC, 0, 1, 1);
        send_cmd(CMD_RELEASE, 5, 1, 0);
        send_cmd(CMD_ALLOC, 0, 1, 1);

        // Random phases, each with its own capacity and idling pattern.
        caps = '{32'd0, 32'hFFFF_FFFF, 32'd4096, $urandom, 32'h0010_0000,
                 32'd1, $urandom_range(64, 1024), 32'hFFFF_FFFF};
        for (int p = 0; p < 8; p++)
        begin
            wait_drained();
            write_capacity(caps[p]);
            case (p % 4)
                0:       begin snd_idle = 0;  rcv_stall = 0;  end
                1:       begin snd_idle = 71; rcv_stall = 0;  end
                2:       begin snd_idle = 0;  rcv_stall = 71; end
                default: begin snd_idle = 25; rcv_stall = 25; end
            endcase
            if (p == 4)
                hold_req = 3000;
            send_cmd(CMD_REINIT, 0, 0, 0);
            repeat (118) random_cmd();
        end

        wait_drained();
        if (sb.errors == 0 && sb.exp_status.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
